FILE: design/half_step_stepper_positioner_macros.svh
// Assertion macros shared by the half-step stepper positioner RTL.
`ifndef HALF_STEP_STEPPER_POSITIONER_MACROS_SVH
`define HALF_STEP_STEPPER_POSITIONER_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define HSSP_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define HSSP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

FILE: design/hssp_pkg.sv
// Types, constants and helper functions of the half-step stepper positioner.
`timescale 1ns / 1ps

package hssp_pkg;

	localparam int REQ_W       = 2;
	localparam int ANGLE_W     = 20;
	localparam int MAG_W       = ANGLE_W;
	localparam int POS_W       = 32;
	localparam int REM_W       = 19;
	localparam int TICK_W      = 16;
	localparam int COIL_W      = 4;
	localparam int PHASE_W     = 3;

	localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REL  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_ABS  = 2'd2;

	localparam int REV_STEPS_DEF = 4096;

	// 5760 units of 1/16 degree per revolution = 2^7 * 45
	localparam int ANGLE_UNITS_PER_REV = 5760;
	localparam int ANGLE_DIV_SHIFT     = 7;
	localparam int ANGLE_ODD           = ANGLE_UNITS_PER_REV >> ANGLE_DIV_SHIFT;

	// floor(y / 45) = (y * RECIP_MUL) >> RECIP_SHIFT, exact for y < 2^29
	localparam int RECIP_SHIFT = 35;
	localparam int RECIP_W     = 30;
	localparam logic [RECIP_W-1:0] RECIP_MUL =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(ANGLE_ODD) - 64'd1) / 64'(ANGLE_ODD));

	// quotient is narrower than y by at least log2(32)
	localparam int QUO_DROP = ANGLE_DIV_SHIFT + $clog2(ANGLE_ODD) - 1;

	localparam logic [REM_W-1:0]  REM_MAX           = '1;
	localparam logic [TICK_W-1:0] STEP_INTERVAL_RST = 16'd2;

	typedef struct packed {
		logic             valid;
		logic [REQ_W-1:0] req;
		logic             ccw;
		logic             neg;
	} conv_ctrl_t;

	function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] ph);
		logic [COIL_W-1:0] c;
		case (ph)
			3'd0:    c = 4'h1;
			3'd1:    c = 4'h3;
			3'd2:    c = 4'h2;
			3'd3:    c = 4'h6;
			3'd4:    c = 4'h4;
			3'd5:    c = 4'hC;
			3'd6:    c = 4'h8;
			default: c = 4'h9;
		endcase
		return c;
	endfunction

	function automatic logic [REM_W-1:0] sat_count(input logic [POS_W-1:0] m);
		logic [REM_W-1:0] r;
		if (m > POS_W'(REM_MAX)) begin
			r = REM_MAX;
		end else begin
			r = m[REM_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: design/hssp_angle_conv.sv
// Request register and pipelined angle-to-steps conversion (truncating toward zero).
`timescale 1ns / 1ps

module hssp_angle_conv #(
	parameter int REV_STEPS = hssp_pkg::REV_STEPS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              adv,
	input  logic                                              in_valid,
	input  logic [hssp_pkg::REQ_W-1:0]                        req_type,
	input  logic signed [hssp_pkg::ANGLE_W-1:0]               angle,
	input  logic                                              ccw,
	output hssp_pkg::conv_ctrl_t                              ctrl,
	output logic [hssp_pkg::MAG_W+$clog2(REV_STEPS+1)-hssp_pkg::QUO_DROP-1:0] steps
);
	import hssp_pkg::*;

	localparam int PROD_W = MAG_W + $clog2(REV_STEPS + 1);
	localparam int Y_W    = PROD_W - ANGLE_DIV_SHIFT;
	localparam int QUO_W  = PROD_W - QUO_DROP;
	localparam int RW     = Y_W + RECIP_W;

	logic                      valid_s1, valid_s2, valid_s3;
	logic [REQ_W-1:0]          req_s1, req_s2, req_s3;
	logic signed [ANGLE_W-1:0] angle_s1;
	logic                      ccw_s1, ccw_s2, ccw_s3;
	logic                      neg_s2, neg_s3;
	logic [PROD_W-1:0]         prod_s2;
	logic [QUO_W-1:0]          quo_s3;

	logic [MAG_W-1:0]          mag;
	logic [PROD_W-1:0]         prod;
	logic [Y_W-1:0]            y;
	logic [RW-1:0]             recip_prod;

	always_comb begin
		mag        = angle_s1[ANGLE_W-1] ? MAG_W'(-angle_s1) : MAG_W'(angle_s1);
		prod       = PROD_W'(mag) * PROD_W'(REV_STEPS);
		y          = prod_s2[PROD_W-1:ANGLE_DIV_SHIFT];
		recip_prod = RW'(y) * RW'(RECIP_MUL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1   <= req_type;
			angle_s1 <= angle;
			ccw_s1   <= ccw;
			req_s2   <= req_s1;
			ccw_s2   <= ccw_s1;
			neg_s2   <= angle_s1[ANGLE_W-1];
			prod_s2  <= prod;
			req_s3   <= req_s2;
			ccw_s3   <= ccw_s2;
			neg_s3   <= neg_s2;
			quo_s3   <= recip_prod[RECIP_SHIFT +: QUO_W];
		end
	end

	assign ctrl.valid = valid_s3;
	assign ctrl.req   = req_s3;
	assign ctrl.ccw   = ccw_s3;
	assign ctrl.neg   = neg_s3;
	assign steps      = quo_s3;

endmodule

FILE: design/hssp_motion.sv
// Motor state: move start, interval counting, half-step phase, coils and position.
`timescale 1ns / 1ps

module hssp_motion #(
	parameter int REV_STEPS = hssp_pkg::REV_STEPS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              adv,
	input  hssp_pkg::conv_ctrl_t                              ctrl,
	input  logic [hssp_pkg::MAG_W+$clog2(REV_STEPS+1)-hssp_pkg::QUO_DROP-1:0] steps,
	input  logic                                              cfg_wr_en,
	input  logic [hssp_pkg::TICK_W-1:0]                       cfg_wr_data,
	output logic                                              out_valid,
	output logic [hssp_pkg::COIL_W-1:0]                       coils,
	output logic signed [hssp_pkg::POS_W-1:0]                 position,
	output logic [hssp_pkg::REM_W-1:0]                        steps_left,
	output logic                                              busy_res,
	output logic                                              rejected
);
	import hssp_pkg::*;
	`include "half_step_stepper_positioner_macros.svh"

	localparam logic signed [POS_W:0] REV_S  = (POS_W+1)'(REV_STEPS);
	localparam logic signed [POS_W:0] HALF_S = (POS_W+1)'(REV_STEPS / 2);

	logic [TICK_W-1:0]  interval_q;
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [REM_W-1:0]   rem_q, rem_d;
	logic               back_q, back_d;
	logic [TICK_W-1:0]  cnt_q, cnt_d;
	logic [COIL_W-1:0]  coil_q, coil_d;
	logic               rej_q, rej_d;
	logic               out_valid_q;

	logic               proc;
	logic               busy;
	logic               step_fire;
	logic [TICK_W:0]    next_cnt;
	logic [POS_W-1:0]   steps_ext;
	logic [POS_W-1:0]   tgt;
	logic [POS_W-1:0]   diff;
	logic signed [POS_W:0] diff_x;
	logic signed [POS_W:0] adj;
	logic signed [POS_W:0] abs_mag_x;
	logic               abs_back;

	assign proc = adv && ctrl.valid;
	assign busy = rem_q != '0;

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		rem_d     = rem_q;
		back_d    = back_q;
		cnt_d     = cnt_q;
		coil_d    = coil_q;
		rej_d     = 1'b0;
		step_fire = 1'b0;

		steps_ext = POS_W'(steps);
		tgt       = ctrl.neg ? -steps_ext : steps_ext;
		diff      = tgt - pos_q;
		diff_x    = {diff[POS_W-1], diff};
		// take the shorter way round
		if (diff_x > HALF_S) begin
			adj = diff_x - REV_S;
		end else if (diff_x < -HALF_S) begin
			adj = diff_x + REV_S;
		end else begin
			adj = diff_x;
		end
		abs_back  = adj[POS_W];
		abs_mag_x = abs_back ? -adj : adj;
		next_cnt  = {1'b0, cnt_q} + (TICK_W+1)'(1);

		if (proc) begin
			case (ctrl.req)
				REQ_TICK: begin
					if (busy) begin
						if (next_cnt >= {1'b0, interval_q}) begin
							cnt_d     = '0;
							step_fire = 1'b1;
						end else begin
							cnt_d = next_cnt[TICK_W-1:0];
						end
					end
				end
				REQ_REL, REQ_ABS: begin
					if (busy) begin
						rej_d = 1'b1;
					end else if (ctrl.req == REQ_REL) begin
						if (!ctrl.neg && steps != '0) begin
							rem_d  = sat_count(steps_ext);
							back_d = ctrl.ccw;
							cnt_d  = '0;
						end
					end else if (adj != '0) begin
						rem_d  = sat_count(abs_mag_x[POS_W-1:0]);
						back_d = abs_back;
						cnt_d  = '0;
					end
				end
				default: begin
					rej_d = 1'b0;
				end
			endcase
		end

		if (step_fire) begin
			phase_d = back_q ? phase_q - PHASE_W'(1) : phase_q + PHASE_W'(1);
			pos_d   = back_q ? pos_q - POS_W'(1) : pos_q + POS_W'(1);
			coil_d  = coil_pattern(phase_d);
			rem_d   = rem_q - REM_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= STEP_INTERVAL_RST;
			phase_q     <= '0;
			pos_q       <= '0;
			rem_q       <= '0;
			back_q      <= 1'b0;
			cnt_q       <= '0;
			coil_q      <= '0;
			rej_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				interval_q <= cfg_wr_data;
			end
			if (adv) begin
				out_valid_q <= ctrl.valid;
			end
			if (proc) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				rem_q   <= rem_d;
				back_q  <= back_d;
				cnt_q   <= cnt_d;
				coil_q  <= coil_d;
				rej_q   <= rej_d;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign coils      = coil_q;
	assign position   = pos_q;
	assign steps_left = rem_q;
	assign busy_res   = busy;
	assign rejected   = rej_q;

	`HSSP_ASSERT_NEXT(a_busy_move_rejected,
		proc && busy && (ctrl.req == REQ_REL || ctrl.req == REQ_ABS), rej_q)
	`HSSP_ASSERT_NEXT(a_step_counts_down, step_fire, rem_q == $past(rem_q) - REM_W'(1))
	`HSSP_ASSERT_NEXT(a_step_moves_one, step_fire,
		(pos_q == $past(pos_q) + POS_W'(1)) || (pos_q == $past(pos_q) - POS_W'(1)))
	`HSSP_ASSERT_IMP(a_coils_follow_phase, coil_q != '0, coil_q == coil_pattern(phase_q))

endmodule

FILE: design/half_step_stepper_positioner.sv
// Half-step stepper positioner top level.
// A request's result leaves the state/result register once it has passed the stages below.
// Throughput: one request per cycle; the input register, the two conversion multiplier
// stages and the state/result register advance together whenever the result is free or taken.
// Reset (arst_n low): coils off, position and steps left zero, step interval 2 ticks.
`timescale 1ns / 1ps

module half_step_stepper_positioner #(
	parameter int REV_STEPS = hssp_pkg::REV_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [hssp_pkg::REQ_W-1:0]          req_type,
	input  logic signed [hssp_pkg::ANGLE_W-1:0] angle,
	input  logic                                ccw,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [hssp_pkg::COIL_W-1:0]         coils,
	output logic signed [hssp_pkg::POS_W-1:0]   position,
	output logic [hssp_pkg::REM_W-1:0]          steps_left,
	output logic                                busy_res,
	output logic                                rejected,
	input  logic                                cfg_wr_en,
	input  logic [hssp_pkg::TICK_W-1:0]         cfg_wr_data
);
	import hssp_pkg::*;

	localparam int QUO_W = MAG_W + $clog2(REV_STEPS + 1) - QUO_DROP;

	logic             adv;
	conv_ctrl_t       ctrl;
	logic [QUO_W-1:0] steps;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	hssp_angle_conv #(
		.REV_STEPS (REV_STEPS)
	) u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.req_type (req_type),
		.angle    (angle),
		.ccw      (ccw),
		.ctrl     (ctrl),
		.steps    (steps)
	);

	hssp_motion #(
		.REV_STEPS (REV_STEPS)
	) u_motion (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.ctrl        (ctrl),
		.steps       (steps),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.coils       (coils),
		.position    (position),
		.steps_left  (steps_left),
		.busy_res    (busy_res),
		.rejected    (rejected)
	);

endmodule
